@@ hdl/plep_pkg.sv @@
// Types, codes and helper functions shared by the packed list entry parser.
`timescale 1ns / 1ps

package plep_pkg;

	// Parse phase of the entry decoder.
	typedef enum logic [2:0] {
		PH_ENC   = 3'd0,
		PH_INT   = 3'd1,
		PH_LEN   = 3'd2,
		PH_STR   = 3'd3,
		PH_BACK  = 3'd4,
		PH_DRAIN = 3'd5
	} phase_t;

	// Result kinds.
	localparam logic [2:0] KIND_INT   = 3'd0;
	localparam logic [2:0] KIND_START = 3'd1;
	localparam logic [2:0] KIND_BYTE  = 3'd2;
	localparam logic [2:0] KIND_DONE  = 3'd3;
	localparam logic [2:0] KIND_END   = 3'd4;
	localparam logic [2:0] KIND_ERR   = 3'd5;

	// Error causes.
	localparam logic [1:0] ERR_BAD_ENC   = 2'd0;
	localparam logic [1:0] ERR_TRUNC     = 2'd1;
	localparam logic [1:0] ERR_AFTER_END = 2'd2;

	// Entry encodings.
	localparam logic [3:0] ENC_UINT7 = 4'd0;
	localparam logic [3:0] ENC_STR6  = 4'd1;
	localparam logic [3:0] ENC_INT13 = 4'd2;
	localparam logic [3:0] ENC_STR12 = 4'd3;
	localparam logic [3:0] ENC_STR32 = 4'd4;
	localparam logic [3:0] ENC_INT16 = 4'd5;
	localparam logic [3:0] ENC_INT24 = 4'd6;
	localparam logic [3:0] ENC_INT32 = 4'd7;
	localparam logic [3:0] ENC_INT64 = 4'd8;

	localparam logic [7:0] END_MARKER = 8'hFF;

	// One result item as it leaves the decode logic.
	typedef struct packed {
		logic        valid;
		logic [2:0]  kind;
		logic [63:0] int_value;
		logic [31:0] str_len;
		logic [7:0]  data_byte;
		logic [1:0]  error_cause;
	} result_t;

	// Number of back-length bytes that follow a payload of the given size.
	function automatic logic [2:0] trailer_len(input logic [32:0] payload);
		logic [2:0] size;
		if (payload <= 33'd127)
			size = 3'd1;
		else if (payload < 33'd16384)
			size = 3'd2;
		else if (payload < 33'd2097152)
			size = 3'd3;
		else if (payload < 33'd268435456)
			size = 3'd4;
		else
			size = 3'd5;
		return size;
	endfunction

	// Data bytes of a little-endian integer encoding.
	function automatic logic [3:0] int_total(input logic [3:0] enc);
		logic [3:0] total;
		case (enc)
			ENC_INT16: total = 4'd2;
			ENC_INT24: total = 4'd3;
			ENC_INT32: total = 4'd4;
			ENC_INT64: total = 4'd8;
			default:   total = 4'd1;
		endcase
		return total;
	endfunction

	function automatic logic [63:0] sign_extend(input logic [3:0] enc, input logic [63:0] v);
		logic [63:0] r;
		case (enc)
			ENC_INT13: r = {{51{v[12]}}, v[12:0]};
			ENC_INT16: r = {{48{v[15]}}, v[15:0]};
			ENC_INT24: r = {{40{v[23]}}, v[23:0]};
			ENC_INT32: r = {{32{v[31]}}, v[31:0]};
			default:   r = v;
		endcase
		return r;
	endfunction

endpackage

@@ hdl/packed_list_entry_parser_unit.sv @@
// Byte-serial decoder for the entry area of a packed list.
`timescale 1ns / 1ps

// The parser takes one byte of the entry area per transfer, with buffer_last
// marking the final byte of the buffer, and gives at most one result per byte:
// an integer (sign-extended, once its back-length has been skipped), a string
// start with its length, one result per string data byte, a string done, a list
// end, or an error. It sustains one byte per clock cycle while no result waits on a
// stalled output; a byte passes through an input register and a result register
// before its result appears on the outputs. Bytes that produce no result never
// wait on a stalled output.
module packed_list_entry_parser_unit
	import plep_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [7:0]         in_byte,
	input  logic               buffer_last,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [2:0]         kind,
	output logic signed [63:0] int_value,
	output logic [31:0]        str_len,
	output logic [7:0]         data_byte,
	output logic [1:0]         error_cause
);

	// Input register.
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;

	// Parse state.
	phase_t      phase_q, phase_d;
	logic [3:0]  enc_q, enc_d;
	logic [63:0] acc_q, acc_d;
	logic [31:0] rem_q, rem_d;
	logic [32:0] payload_q, payload_d;
	logic [2:0]  blrem_q, blrem_d;

	// Result register.
	logic        out_valid_s2;
	logic [2:0]  kind_s2;
	logic [63:0] int_value_s2;
	logic [31:0] str_len_s2;
	logic [7:0]  data_byte_s2;
	logic [1:0]  cause_s2;

	result_t res;
	logic    advance;

	// Shared data path terms.
	logic [2:0]  int_idx;
	logic [63:0] int_acc;
	logic [1:0]  len_idx;
	logic [63:0] len_acc;
	logic [31:0] len12;
	logic        rem_one;

	assign int_idx = 3'(int_total(enc_q) - rem_q[3:0]);
	assign int_acc = (enc_q == ENC_INT13) ? {acc_q[55:0], byte_s1}
		: (acc_q | (64'(byte_s1) << {int_idx, 3'b000}));
	assign len_idx = 2'(3'd4 - rem_q[2:0]);
	assign len_acc = acc_q | (64'(byte_s1) << {len_idx, 3'b000});
	assign len12   = {acc_q[23:0], byte_s1};
	assign rem_one = (rem_q == 32'd1);

	// Next parse state.
	always_comb begin
		phase_d   = phase_q;
		enc_d     = enc_q;
		acc_d     = acc_q;
		rem_d     = rem_q;
		payload_d = payload_q;
		blrem_d   = blrem_q;
		case (phase_q)
			PH_DRAIN: begin
				if (last_s1)
					phase_d = PH_ENC;
			end
			PH_INT: begin
				if (last_s1) begin
					phase_d = PH_ENC;
				end else begin
					acc_d = int_acc;
					rem_d = rem_q - 32'd1;
					if (rem_one) begin
						acc_d   = sign_extend(enc_q, int_acc);
						blrem_d = trailer_len(payload_q);
						phase_d = PH_BACK;
					end
				end
			end
			PH_LEN: begin
				if (last_s1) begin
					phase_d = PH_ENC;
				end else if (enc_q == ENC_STR12) begin
					payload_d = 33'd2 + 33'(len12);
					acc_d     = 64'(len12);
					if (len12 != 32'd0) begin
						rem_d   = len12;
						phase_d = PH_STR;
					end else begin
						blrem_d = trailer_len(33'd2 + 33'(len12));
						phase_d = PH_BACK;
					end
				end else begin
					acc_d = len_acc;
					rem_d = rem_q - 32'd1;
					if (rem_one) begin
						payload_d = 33'd5 + 33'(len_acc[31:0]);
						acc_d     = 64'(len_acc[31:0]);
						if (len_acc[31:0] != 32'd0) begin
							rem_d   = len_acc[31:0];
							phase_d = PH_STR;
						end else begin
							blrem_d = trailer_len(33'd5 + 33'(len_acc[31:0]));
							phase_d = PH_BACK;
						end
					end
				end
			end
			PH_STR: begin
				if (last_s1) begin
					phase_d = PH_ENC;
				end else begin
					rem_d = rem_q - 32'd1;
					if (rem_one) begin
						blrem_d = trailer_len(payload_q);
						phase_d = PH_BACK;
					end
				end
			end
			PH_BACK: begin
				if (last_s1) begin
					phase_d = PH_ENC;
				end else begin
					blrem_d = blrem_q - 3'd1;
					if (blrem_q == 3'd1)
						phase_d = PH_ENC;
				end
			end
			default: begin
				phase_d = PH_ENC;
				if (byte_s1 == END_MARKER) begin
					if (!last_s1)
						phase_d = PH_DRAIN;
				end else if (byte_s1 inside {[8'hF5:8'hFE]}) begin
					if (!last_s1)
						phase_d = PH_DRAIN;
				end else if (!last_s1) begin
					acc_d = '0;
					if (!byte_s1[7]) begin
						enc_d     = ENC_UINT7;
						acc_d     = 64'(byte_s1);
						payload_d = 33'd1;
						blrem_d   = trailer_len(33'd1);
						phase_d   = PH_BACK;
					end else if (byte_s1[7:6] == 2'b10) begin
						enc_d     = ENC_STR6;
						payload_d = 33'd1 + 33'(byte_s1[5:0]);
						acc_d     = 64'(byte_s1[5:0]);
						if (byte_s1[5:0] != 6'd0) begin
							rem_d   = 32'(byte_s1[5:0]);
							phase_d = PH_STR;
						end else begin
							blrem_d = trailer_len(33'd1);
							phase_d = PH_BACK;
						end
					end else if (byte_s1[7:5] == 3'b110) begin
						enc_d     = ENC_INT13;
						acc_d     = 64'(byte_s1[4:0]);
						rem_d     = 32'd1;
						payload_d = 33'd2;
						phase_d   = PH_INT;
					end else if (byte_s1[7:4] == 4'b1110) begin
						enc_d   = ENC_STR12;
						acc_d   = 64'(byte_s1[3:0]);
						rem_d   = 32'd1;
						phase_d = PH_LEN;
					end else if (byte_s1 == 8'hF0) begin
						enc_d   = ENC_STR32;
						rem_d   = 32'd4;
						phase_d = PH_LEN;
					end else begin
						// The four fixed-width integers follow 0xF0 in order of size.
						enc_d     = ENC_INT16 + 4'(byte_s1[2:0] - 3'd1);
						rem_d     = 32'(int_total(ENC_INT16 + 4'(byte_s1[2:0] - 3'd1)));
						payload_d = 33'd1
							+ 33'(int_total(ENC_INT16 + 4'(byte_s1[2:0] - 3'd1)));
						phase_d   = PH_INT;
					end
				end
			end
		endcase
	end

	// Result for the byte in the input register.
	always_comb begin
		res = '0;
		case (phase_q)
			PH_DRAIN: begin
				res.valid = 1'b0;
			end
			PH_INT: begin
				if (last_s1) begin
					res.valid       = 1'b1;
					res.kind        = KIND_ERR;
					res.error_cause = ERR_TRUNC;
				end
			end
			PH_LEN: begin
				if (last_s1) begin
					res.valid       = 1'b1;
					res.kind        = KIND_ERR;
					res.error_cause = ERR_TRUNC;
				end else if (enc_q == ENC_STR12) begin
					res.valid   = 1'b1;
					res.kind    = KIND_START;
					res.str_len = len12;
				end else if (rem_one) begin
					res.valid   = 1'b1;
					res.kind    = KIND_START;
					res.str_len = len_acc[31:0];
				end
			end
			PH_STR: begin
				res.valid = 1'b1;
				if (last_s1) begin
					res.kind        = KIND_ERR;
					res.error_cause = ERR_TRUNC;
				end else begin
					res.kind      = KIND_BYTE;
					res.data_byte = byte_s1;
				end
			end
			PH_BACK: begin
				if (last_s1) begin
					res.valid       = 1'b1;
					res.kind        = KIND_ERR;
					res.error_cause = ERR_TRUNC;
				end else if (blrem_q == 3'd1) begin
					res.valid = 1'b1;
					if (enc_q == ENC_STR6 || enc_q == ENC_STR12 || enc_q == ENC_STR32) begin
						res.kind = KIND_DONE;
					end else begin
						res.kind      = KIND_INT;
						res.int_value = acc_q;
					end
				end
			end
			default: begin
				if (byte_s1 == END_MARKER) begin
					res.valid = 1'b1;
					if (last_s1) begin
						res.kind = KIND_END;
					end else begin
						res.kind        = KIND_ERR;
						res.error_cause = ERR_AFTER_END;
					end
				end else if (byte_s1 inside {[8'hF5:8'hFE]}) begin
					res.valid       = 1'b1;
					res.kind        = KIND_ERR;
					res.error_cause = ERR_BAD_ENC;
				end else if (last_s1) begin
					res.valid       = 1'b1;
					res.kind        = KIND_ERR;
					res.error_cause = ERR_TRUNC;
				end else if (byte_s1[7:6] == 2'b10) begin
					res.valid   = 1'b1;
					res.kind    = KIND_START;
					res.str_len = 32'(byte_s1[5:0]);
				end
			end
		endcase
	end

	// A byte moves on unless it has a result and the result register is held.
	assign advance  = valid_s1 && (!res.valid || !out_valid_s2 || !out_stall);
	assign in_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			byte_s1 <= in_byte;
			last_s1 <= buffer_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_ENC;
			enc_q     <= ENC_UINT7;
			acc_q     <= '0;
			rem_q     <= '0;
			payload_q <= '0;
			blrem_q   <= '0;
		end else if (advance) begin
			phase_q   <= phase_d;
			enc_q     <= enc_d;
			acc_q     <= acc_d;
			rem_q     <= rem_d;
			payload_q <= payload_d;
			blrem_q   <= blrem_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_s2 <= 1'b0;
		end else if (advance && res.valid) begin
			out_valid_s2 <= 1'b1;
		end else if (!out_stall) begin
			out_valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res.valid) begin
			kind_s2      <= res.kind;
			int_value_s2 <= res.int_value;
			str_len_s2   <= res.str_len;
			data_byte_s2 <= res.data_byte;
			cause_s2     <= res.error_cause;
		end
	end

	assign out_valid   = out_valid_s2;
	assign kind        = kind_s2;
	assign int_value   = signed'(int_value_s2);
	assign str_len     = str_len_s2;
	assign data_byte   = data_byte_s2;
	assign error_cause = cause_s2;

endmodule
